@@ hdl/ddrw_pkg.sv @@
// Shared types and constants for the display dirty row writer.
package ddrw_pkg;

    localparam int ROW_COUNT_DEFAULT = 8;
    localparam int MAX_ROWS          = 8;
    localparam int ROW_W             = 8;
    localparam int DEV_ADDR_W        = 7;
    localparam int ROW_IDX_W         = 3;
    localparam int IN_DATA_W         = 72;
    localparam int OUT_DATA_W        = 16;
    localparam int OUT_USER_W        = 4;

    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'h70;
    localparam logic [ROW_W-1:0]      PAD_BYTE       = 8'h00;

    // Bit positions within the output tuser field.
    localparam int USER_BYTE_VALID = 0;
    localparam int USER_MSG_START  = 1;
    localparam int USER_MSG_END    = 2;
    localparam int USER_ACCEPTED   = 3;

    // Bit position of the bus ready flag within the input tdata field.
    localparam int IN_BUS_READY_BIT = 64;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_STATUS,
        KIND_ADDR,
        KIND_DATA,
        KIND_PAD
    } out_kind_t;

    typedef struct packed {
        out_kind_t kind;
        logic      load;
        logic      start_run;
        logic      finish_row;
        logic      step_pad;
    } ddrw_cmd_t;

    typedef struct packed {
        logic bus_ready;
        logic dirty;
        logic run_end;
        logic rest_empty;
    } ddrw_stat_t;

endpackage

@@ hdl/ddrw_ctrl.sv @@
// Controller state machine that sequences the write messages of one frame.
module ddrw_ctrl
    import ddrw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ddrw_stat_t stat,
    output ddrw_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STATUS,
        S_ADDR,
        S_DATA,
        S_PAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.kind       = KIND_NONE;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!stat.bus_ready || !stat.dirty)
                    begin
                        state_next = S_STATUS;
                    end
                    else
                    begin
                        state_next = S_ADDR;
                    end
                end
            end
            S_STATUS:
            begin
                cmd.kind  = KIND_STATUS;
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADDR:
            begin
                cmd.kind  = KIND_ADDR;
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.start_run = 1'b1;
                    state_next    = S_DATA;
                end
            end
            S_DATA:
            begin
                cmd.kind  = KIND_DATA;
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.finish_row = 1'b1;
                    if (!stat.run_end)
                    begin
                        state_next = S_PAD;
                    end
                    else if (stat.rest_empty)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ADDR;
                    end
                end
            end
            S_PAD:
            begin
                cmd.kind  = KIND_PAD;
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.step_pad = 1'b1;
                    state_next   = S_DATA;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/ddrw_datapath.sv @@
// Datapath holding the shadow rows, the frame, the pending row mask and the output mux.
module ddrw_datapath
    import ddrw_pkg::*;
#(
    parameter int ROW_COUNT = ROW_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  cfg_valid,
    input  logic [DEV_ADDR_W-1:0] cfg_data,
    input  ddrw_cmd_t             cmd,
    output ddrw_stat_t            stat,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [OUT_USER_W-1:0] out_user,
    output logic                  out_last
);

    logic [ROW_W-1:0]      shadow_reg [ROW_COUNT];
    logic [ROW_W-1:0]      rows_reg   [MAX_ROWS];
    logic [MAX_ROWS-1:0]   pending_reg;
    logic [ROW_IDX_W-1:0]  index_reg;
    logic                  acc_reg;
    logic [DEV_ADDR_W-1:0] dev_addr_reg;

    logic [ROW_W-1:0]      row_in [MAX_ROWS];
    logic [MAX_ROWS-1:0]   changed;
    logic                  bus_ready_in;
    logic [ROW_IDX_W-1:0]  first_idx;
    logic                  run_end;
    logic                  rest_empty;
    logic [ROW_W-1:0]      out_byte;
    logic [DEV_ADDR_W-1:0] target_address;

    assign bus_ready_in = in_data[IN_BUS_READY_BIT];

    always_comb
    begin
        changed = '0;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            row_in[i] = in_data[ROW_W*i +: ROW_W];
        end
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            changed[i] = (row_in[i] != shadow_reg[i]);
        end
    end

    always_comb
    begin
        first_idx = '0;
        for (int i = MAX_ROWS - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                first_idx = ROW_IDX_W'(i);
            end
        end
    end

    assign run_end    = (index_reg == ROW_IDX_W'(MAX_ROWS - 1))
                        || !pending_reg[index_reg + ROW_IDX_W'(1)];
    assign rest_empty = ((pending_reg & ~(MAX_ROWS'(1) << index_reg)) == '0);

    assign stat.bus_ready  = bus_ready_in;
    assign stat.dirty      = (changed != '0);
    assign stat.run_end    = run_end;
    assign stat.rest_empty = rest_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
            begin
                shadow_reg[i] <= '0;
            end
            pending_reg  <= '0;
            index_reg    <= '0;
            acc_reg      <= 1'b0;
            dev_addr_reg <= DEV_ADDR_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                dev_addr_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                acc_reg <= bus_ready_in;
                if (bus_ready_in)
                begin
                    pending_reg <= changed;
                    for (int i = 0; i < ROW_COUNT; i++)
                    begin
                        shadow_reg[i] <= row_in[i];
                    end
                end
                else
                begin
                    pending_reg <= '0;
                end
            end
            if (cmd.start_run)
            begin
                index_reg <= first_idx;
            end
            if (cmd.finish_row)
            begin
                pending_reg[index_reg] <= 1'b0;
            end
            if (cmd.step_pad)
            begin
                index_reg <= index_reg + ROW_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                rows_reg[i] <= row_in[i];
            end
        end
    end

    always_comb
    begin
        out_byte       = '0;
        target_address = '0;
        out_user       = '0;
        out_last       = 1'b0;
        unique case (cmd.kind)
            KIND_NONE:
            begin
                out_last = 1'b0;
            end
            KIND_STATUS:
            begin
                out_user[USER_ACCEPTED] = acc_reg;
                out_last                = 1'b1;
            end
            KIND_ADDR:
            begin
                out_byte                  = {4'b0000, first_idx, 1'b0};
                target_address            = dev_addr_reg;
                out_user[USER_BYTE_VALID] = 1'b1;
                out_user[USER_MSG_START]  = 1'b1;
                out_user[USER_ACCEPTED]   = 1'b1;
            end
            KIND_DATA:
            begin
                out_byte                  = rows_reg[index_reg];
                target_address            = dev_addr_reg;
                out_user[USER_BYTE_VALID] = 1'b1;
                out_user[USER_MSG_END]    = run_end;
                out_user[USER_ACCEPTED]   = 1'b1;
                out_last                  = run_end && rest_empty;
            end
            KIND_PAD:
            begin
                out_byte                  = PAD_BYTE;
                target_address            = dev_addr_reg;
                out_user[USER_BYTE_VALID] = 1'b1;
                out_user[USER_ACCEPTED]   = 1'b1;
            end
            default:
            begin
                out_last = 1'b0;
            end
        endcase
    end

    assign out_data = {1'b0, target_address, out_byte};

endmodule

@@ hdl/display_dirty_row_writer.sv @@
// Top level of the display dirty row writer.
// A frame of eight row bytes is taken and then its results are presented
// one per cycle on the output stream while it does not stall: a single
// status transaction when the bus is busy or no row changed, otherwise
// each run of changed rows as an address byte followed by the row bytes
// with pad bytes between them. A frame gives 1 to 16 results; the
// controller emits one message byte per cycle unless the output stalls
// and takes the next frame only after the last result of the current one
// has been transferred. The shadow copy of the rows is cleared by reset,
// and the device address may be written whenever the block is idle.
module display_dirty_row_writer
    import ddrw_pkg::*;
#(
    parameter int ROW_COUNT = ROW_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // row_zero .. row_seven in bits 63:0, bus_ready in bit 64, zero fill above.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // out_byte in bits 7:0, target_address in bits 14:8, zero fill in bit 15.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // byte_valid, message_start, message_end, accepted from bit 0 upwards.
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [DEV_ADDR_W-1:0] cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    ddrw_cmd_t  cmd;
    ddrw_stat_t stat;

    assign cfg_ready = 1'b1;

    ddrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ddrw_datapath #(
        .ROW_COUNT (ROW_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

@@ hdl/ddrw_checker.sv @@
// Port-level checker for the display dirty row writer and its bind statement.
module ddrw_checker
    import ddrw_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready
);

    // A stalled output transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // A new frame is taken only when no result is outstanding.
    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    // Every accepted frame produces a result in the following cycle.
    a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted frame produced no result");

    // A message start is never the final result of a frame.
    a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_MSG_START] |-> !m_axis_tlast)
        else $error("message start marked as last result");

    // A refused frame gives one empty final result.
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[USER_ACCEPTED]
        |-> m_axis_tlast && !m_axis_tuser[USER_BYTE_VALID])
        else $error("refused frame result malformed");

endmodule

bind display_dirty_row_writer ddrw_checker u_ddrw_checker (.*);

@@ tb/display_dirty_row_writer_test.sv @@
// Self-checking testbench for the display dirty row writer.
`timescale 1ns / 1ps

module display_dirty_row_writer_test;
    import ddrw_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [ROW_W-1:0]      out_byte;
        logic [DEV_ADDR_W-1:0] target_address;
        logic                  byte_valid;
        logic                  message_start;
        logic                  message_end;
        logic                  accepted;
        logic                  frame_last;
    } msg_byte_t;

    class dirty_row_scoreboard;
        logic [ROW_W-1:0]      shadow [MAX_ROWS];
        logic [DEV_ADDR_W-1:0] dev_addr;
        msg_byte_t             pending_bytes [$];
        int                    errors;
        int                    frames;
        int                    busy_frames;
        int                    quiet_frames;
        int                    checked;

        function new();
            foreach (shadow[i])
                shadow[i] = '0;
            dev_addr     = DEV_ADDR_RESET;
            errors       = 0;
            frames       = 0;
            busy_frames  = 0;
            quiet_frames = 0;
            checked      = 0;
        endfunction

        function void push_byte(logic [ROW_W-1:0] value, logic first, logic final_byte);
            msg_byte_t entry;
            entry = '{value, dev_addr, 1'b1, first, final_byte, 1'b1, 1'b0};
            pending_bytes.push_back(entry);
        endfunction

        function void note_frame(logic [IN_DATA_W-1:0] data);
            logic [ROW_W-1:0] rows [MAX_ROWS];
            logic             changed [MAX_ROWS];
            msg_byte_t        tail;
            int               idx;
            int               run_first;
            int               run_last;
            int               count_before;
            frames++;
            if (!data[IN_BUS_READY_BIT])
            begin
                busy_frames++;
                pending_bytes.push_back('{8'h00, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
                return;
            end
            for (idx = 0; idx < MAX_ROWS; idx++)
            begin
                rows[idx]    = data[ROW_W*idx +: ROW_W];
                changed[idx] = rows[idx] != shadow[idx];
            end
            count_before = pending_bytes.size();
            idx = 0;
            while (idx < MAX_ROWS)
            begin
                if (!changed[idx])
                begin
                    idx++;
                end
                else
                begin
                    run_first = idx;
                    run_last  = idx;
                    while (run_last + 1 < MAX_ROWS && changed[run_last + 1])
                        run_last++;
                    push_byte(ROW_W'(2 * run_first), 1'b1, 1'b0);
                    for (int r = run_first; r <= run_last; r++)
                    begin
                        push_byte(rows[r], 1'b0, r == run_last);
                        if (r != run_last)
                            push_byte(PAD_BYTE, 1'b0, 1'b0);
                    end
                    idx = run_last + 1;
                end
            end
            foreach (shadow[i])
                shadow[i] = rows[i];
            if (pending_bytes.size() == count_before)
            begin
                quiet_frames++;
                pending_bytes.push_back('{8'h00, 7'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1});
            end
            else
            begin
                tail = pending_bytes.pop_back();
                tail.frame_last = 1'b1;
                pending_bytes.push_back(tail);
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_result(msg_byte_t got);
            msg_byte_t want;
            checked++;
            if (pending_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, expected none, got 0x%0h", $time, got);
                return;
            end
            want = pending_bytes.pop_front();
            check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            check_field("target_address", 32'(want.target_address), 32'(got.target_address));
            check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            check_field("message_start", 32'(want.message_start), 32'(got.message_start));
            check_field("message_end", 32'(want.message_end), 32'(got.message_end));
            check_field("accepted", 32'(want.accepted), 32'(got.accepted));
            check_field("last", 32'(want.frame_last), 32'(got.frame_last));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DEV_ADDR_W-1:0] cfg_data;
    logic                  cfg_valid;
    logic                  cfg_ready;

    dirty_row_scoreboard   sb;
    int                    send_idle;
    int                    recv_stall;
    int                    quiet_cycles;
    logic [63:0]           sent_rows;

    display_dirty_row_writer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result('{m_axis_tdata[7:0], m_axis_tdata[14:8],
                                  m_axis_tuser[USER_BYTE_VALID], m_axis_tuser[USER_MSG_START],
                                  m_axis_tuser[USER_MSG_END], m_axis_tuser[USER_ACCEPTED],
                                  m_axis_tlast});
            if (s_axis_tvalid && s_axis_tready)
                sb.note_frame(s_axis_tdata);
            if (cfg_valid && cfg_ready)
                sb.dev_addr = cfg_data;
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[display_dirty_row_writer] ERROR");
                $finish;
            end
        end
    end

    task automatic send_frame(input logic [63:0] rows, input logic ready);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, ready, rows};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (ready)
            sent_rows = rows;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_address(input logic [DEV_ADDR_W-1:0] addr);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_frames(input int count);
        logic [63:0] next_rows;
        int          change_pct;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(3))
                0:       change_pct = 0;
                1:       change_pct = 15;
                2:       change_pct = 40;
                default: change_pct = 100;
            endcase
            next_rows = sent_rows;
            for (int i = 0; i < MAX_ROWS; i++)
                if ($urandom_range(99) < change_pct)
                    next_rows[ROW_W*i +: ROW_W] = ROW_W'($urandom_range(255));
            send_frame(next_rows, $urandom_range(99) < 85);
            if ($urandom_range(49) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        cfg_data      = '0;
        cfg_valid     = 1'b0;
        send_idle     = 0;
        recv_stall    = 0;
        quiet_cycles  = 0;
        sent_rows     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames run with the reset device address.
        send_frame(64'h0, 1'b1);
        send_frame('1, 1'b0);
        send_frame('1, 1'b1);
        send_frame('1, 1'b1);
        send_frame(64'h0, 1'b0);
        send_frame(64'h00FF_00FF_00FF_00FF, 1'b1);
        send_frame(64'h0, 1'b1);
        send_frame(64'hA500_0000_0000_0000, 1'b1);
        send_frame(64'hA500_0000_0000_005A, 1'b1);
        send_frame(64'hA5C3_0000_0081_7E5A, 1'b1);
        send_frame(64'h5555_AAAA_5555_AAAA, 1'b1);
        send_frame(64'h5555_AAAA_5555_AAAA, 1'b1);
        send_frame(64'hFFFF_FFFF_0000_0000, 1'b0);
        send_frame(64'h8040_2010_0804_0201, 1'b1);
        send_frame(64'h0102_0408_1020_4080, 1'b1);
        send_frame(64'hFF00_0000_0000_00FF, 1'b1);
        drain_results();

        write_address(7'h00);
        random_frames(110);
        drain_results();

        send_idle = 53;
        write_address(7'h7F);
        random_frames(110);
        drain_results();

        send_idle  = 0;
        recv_stall = 53;
        write_address(DEV_ADDR_W'($urandom_range(127)));
        random_frames(110);
        drain_results();

        send_idle  = 35;
        recv_stall = 35;
        write_address(7'h2A);
        random_frames(110);
        drain_results();

        $display("Checked %0d frames (%0d with the bus busy, %0d unchanged) and %0d results.",
                 sb.frames, sb.busy_frames, sb.quiet_frames, sb.checked);
        $display("Device addresses 0x70, 0x00, 0x7f and others under four pacing mixes.");
        if (sb.errors == 0 && sb.pending_bytes.size() == 0)
            $display("[display_dirty_row_writer] OK");
        else
            $display("[display_dirty_row_writer] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hdl/ddrw_pkg.sv
hdl/ddrw_ctrl.sv
hdl/ddrw_datapath.sv
hdl/display_dirty_row_writer.sv
hdl/ddrw_checker.sv
tb/display_dirty_row_writer_test.sv
